// ===== hw/rtl/aioe_pkg.sv =====
// ----------------------------------------------------------------------------
// aioe_pkg
// Types, opcodes and word builders for the immediate-operation encoder.
// ----------------------------------------------------------------------------
package aioe_pkg;

    // request modes
    localparam logic [1:0] MODE_SET = 2'd0;
    localparam logic [1:0] MODE_ADD = 2'd1;
    localparam logic [1:0] MODE_SUB = 2'd2;

    // wide-move kinds (opc field)
    localparam logic [1:0] MT_INVERT = 2'd0;
    localparam logic [1:0] MT_ZERO   = 2'd2;
    localparam logic [1:0] MT_KEEP   = 2'd3;

    localparam logic [31:0] MOV_BASE  = 32'h9280_0000;
    localparam logic [4:0]  TMP_REG   = 5'd17;
    localparam logic [7:0]  OP_ADD_I  = 8'h91;
    localparam logic [7:0]  OP_SUB_I  = 8'hd1;
    localparam logic [7:0]  OP_ADD_R  = 8'h8b;
    localparam logic [7:0]  OP_SUB_R  = 8'hcb;
    localparam logic [15:0] PART_ONES = 16'hffff;

    localparam int MAX_WORDS = 5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  dest_register;
        logic [63:0] immediate;
    } t_cmd;

    typedef struct packed {
        logic [31:0] instr_word;
        logic        last_word;
    } t_result;

    function automatic logic [31:0] f_wide_move(input logic [1:0]  kind,
                                                input logic [15:0] part,
                                                input logic [1:0]  level,
                                                input logic [4:0]  rd);
        logic [15:0] imm16;
        imm16 = (kind == MT_INVERT) ? ~part : part;
        return MOV_BASE | {1'b0, kind, 29'd0} | {9'd0, level, 21'd0}
             | {11'd0, imm16, 5'd0} | {27'd0, rd};
    endfunction

    function automatic logic [31:0] f_arith_imm(input logic [7:0]  opbyte,
                                                input logic [4:0]  rd,
                                                input logic [11:0] imm12,
                                                input logic        high);
        return {opbyte, 1'b0, high, imm12, rd, rd};
    endfunction

    function automatic logic [31:0] f_arith_reg(input logic [7:0] opbyte,
                                                input logic [4:0] rd);
        return {opbyte, 3'd0, TMP_REG, 6'd0, rd, rd};
    endfunction

endpackage

// ===== hw/rtl/arm64_immediate_op_encoder.sv =====
// ----------------------------------------------------------------------------
// arm64_immediate_op_encoder
// Turns a set/add/sub-immediate request into a sequence of 32-bit
// instruction words, one word per result beat.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on i_cmd at a rising edge where start is high and
//   busy is low. Its words leave on o_result, one per cycle, each marked by
//   o_strobe for exactly one cycle; o_result.last_word flags the final word.
//   The receiver cannot stall, so words stream out without gaps.
// First word: with the result side idle, the first word passes the input
//   register, then the result register, before it is on the outputs; behind
//   a request still draining it follows that one's last word.
// Throughput: a request yielding n words (1..5) holds the result side until
//   its last word is out; a request in the unused mode yields nothing.
//   The next request is taken while the current one is still draining, so
//   requests yielding words follow each other with no idle cycles. The rate
//   is set by the single result port emitting one word per cycle.
// Reset: synchronous, active low; clears the input and buffer valid state
//   and the strobe. No request in flight survives reset.
// ----------------------------------------------------------------------------
module arm64_immediate_op_encoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  aioe_pkg::t_cmd i_cmd,
    output logic           o_strobe,
    output aioe_pkg::t_result o_result
);
    import aioe_pkg::*;

    localparam int BUF_DEPTH = MAX_WORDS - 1;

    t_cmd        r_in;
    logic        r_in_vld, n_in_vld;
    logic [31:0] r_buf [BUF_DEPTH];
    logic [31:0] n_buf [BUF_DEPTH];
    logic [2:0]  r_left, n_left;
    t_result     r_out, n_out;
    logic        r_strobe, n_strobe;

    logic [31:0] bw [4];
    logic [2:0]  bn;
    logic [31:0] w  [MAX_WORDS];
    logic [2:0]  cnt;
    logic        accept;

    assign busy   = r_in_vld && (r_left != 3'd0);
    assign accept = start && !busy;

    // build the MOVZ/MOVN/MOVK chain for the registered immediate
    always_comb begin
        logic        neg;
        logic [15:0] dflt;
        logic [1:0]  lead;
        logic [4:0]  rd;
        logic [15:0] part;
        neg  = r_in.immediate[63];
        dflt = neg ? PART_ONES : 16'd0;
        lead = neg ? MT_INVERT : MT_ZERO;
        rd   = (r_in.mode == MODE_SET) ? r_in.dest_register : TMP_REG;
        bn   = 3'd0;
        for (int k = 0; k < 4; k++) begin
            bw[k] = 32'd0;
        end
        for (int i = 0; i < 4; i++) begin
            part = r_in.immediate[16*i +: 16];
            if (part != dflt) begin
                bw[bn[1:0]] = f_wide_move((bn != 3'd0) ? MT_KEEP : lead, part, 2'(i), rd);
                bn = bn + 3'd1;
            end
        end
        if (bn == 3'd0) begin
            bw[0] = f_wide_move(lead, dflt, 2'd0, rd);
            bn    = 3'd1;
        end
    end

    // full word list for the request
    always_comb begin
        logic [7:0] op_i;
        logic [7:0] op_r;
        op_i = (r_in.mode == MODE_ADD) ? OP_ADD_I : OP_SUB_I;
        op_r = (r_in.mode == MODE_ADD) ? OP_ADD_R : OP_SUB_R;
        for (int k = 0; k < MAX_WORDS; k++) begin
            w[k] = 32'd0;
        end
        cnt = 3'd0;
        case (r_in.mode)
            MODE_SET: begin
                for (int k = 0; k < 4; k++) begin
                    w[k] = bw[k];
                end
                cnt = bn;
            end
            MODE_ADD, MODE_SUB: begin
                if (r_in.immediate[63:12] == 52'd0) begin
                    w[0] = f_arith_imm(op_i, r_in.dest_register,
                                       r_in.immediate[11:0], 1'b0);
                    cnt  = 3'd1;
                end else if (r_in.immediate[63:24] == 40'd0) begin
                    w[0] = f_arith_imm(op_i, r_in.dest_register,
                                       r_in.immediate[23:12], 1'b1);
                    w[1] = f_arith_imm(op_i, r_in.dest_register,
                                       r_in.immediate[11:0], 1'b0);
                    cnt  = (r_in.immediate[11:0] != 12'd0) ? 3'd2 : 3'd1;
                end else begin
                    for (int k = 0; k < 4; k++) begin
                        w[k] = bw[k];
                    end
                    w[bn] = f_arith_reg(op_r, r_in.dest_register);
                    cnt   = bn + 3'd1;
                end
            end
            default: begin
                cnt = 3'd0;
            end
        endcase
    end

    always_comb begin
        n_in_vld = r_in_vld;
        n_buf    = r_buf;
        n_left   = r_left;
        n_out    = r_out;
        n_strobe = 1'b0;
        if (r_left != 3'd0) begin
            // drain the buffer, one beat a cycle
            n_out.instr_word = r_buf[0];
            n_out.last_word  = (r_left == 3'd1);
            n_strobe         = 1'b1;
            for (int k = 0; k < BUF_DEPTH - 1; k++) begin
                n_buf[k] = r_buf[k + 1];
            end
            n_left = r_left - 3'd1;
        end else if (r_in_vld) begin
            // emit the first word now, hold the rest
            n_in_vld = 1'b0;
            if (cnt != 3'd0) begin
                n_out.instr_word = w[0];
                n_out.last_word  = (cnt == 3'd1);
                n_strobe         = 1'b1;
                for (int k = 0; k < BUF_DEPTH; k++) begin
                    n_buf[k] = w[k + 1];
                end
                n_left = cnt - 3'd1;
            end
        end
        if (accept) begin
            n_in_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_left   <= 3'd0;
            r_strobe <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_cmd;
        end
        r_buf <= n_buf;
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // words of one request leave back to back
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_word |=> o_strobe)
        else $error("gap inside a request's word sequence");

    a_buf_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left != 3'd0 |=> o_strobe)
        else $error("buffered word not emitted");

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 3'(BUF_DEPTH))
        else $error("buffer count exceeds depth");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> r_in_vld)
        else $error("accepted request not held");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_word |-> r_left == 3'd0)
        else $error("words left after last word");

endmodule
